### hdl/mse_pkg.sv
`timescale 1ns / 1ps

package mse_pkg;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTIU = 6'h0b;
    localparam logic [5:0] OP_ANDI  = 6'h0c;
    localparam logic [5:0] OP_ORI   = 6'h0d;
    localparam logic [5:0] OP_LUI   = 6'h0f;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2b;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_OR,
        ALU_NOR,
        ALU_SLTU,
        ALU_SLL,
        ALU_SRL,
        ALU_PASSB,
        ALU_ZERO
    } alu_op_t;

    typedef struct packed {
        logic [5:0]  op;
        logic [5:0]  funct;
        logic [4:0]  shift_amount;
        logic [15:0] immediate;
        logic [31:0] first_operand;
        logic [31:0] second_operand;
        logic [31:0] instr_address;
    } mse_in_t;

    typedef struct packed {
        logic [31:0] alu_result;
        logic        branch_taken;
        logic [31:0] branch_target;
        logic        writes_register;
        logic        reads_memory;
        logic        writes_memory;
        logic [31:0] store_data;
        logic        illegal;
    } mse_out_t;

    typedef struct packed {
        logic writes_register;
        logic reads_memory;
        logic writes_memory;
        logic illegal;
        logic is_branch;
        logic is_beq;
    } ctrl_t;

    typedef struct packed {
        alu_op_t     alu_op;
        ctrl_t       ctrl;
        logic [31:0] a;
        logic [31:0] b;
        logic [4:0]  shamt;
        logic [31:0] pc4;
        logic [31:0] boff;
        logic [31:0] sdata;
    } s1_t;

    typedef struct packed {
        alu_op_t     alu_op;
        ctrl_t       ctrl;
        logic [31:0] b;
        logic [31:0] sum;
        logic [32:0] diff;
        logic [31:0] logic_r;
        logic [31:0] shifted;
        logic        eq;
        logic [31:0] target;
        logic [31:0] sdata;
    } s2_t;

endpackage

### hdl/mse_instr_if.sv
`timescale 1ns / 1ps

interface mse_instr_if;
    logic             valid;
    logic             ready;
    mse_pkg::mse_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/mse_result_if.sv
`timescale 1ns / 1ps

interface mse_result_if;
    logic              valid;
    logic              ready;
    mse_pkg::mse_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/mips_subset_execute_stage.sv
`timescale 1ns / 1ps
// Stages in order: decode, ALU, result select; each holds its item in a register.
// Throughput: one item per cycle while results are taken; each stage holds
// one item and takes a new one whenever it is empty or its item moves on, so
// a stalled result keeps the earlier stages filling.
// Reset: rst_n clears all stage valid bits asynchronously; data registers are not reset.

module mips_subset_execute_stage (
    input  logic         clk,
    input  logic         rst_n,
    mse_instr_if.sink    instr,
    mse_result_if.source result
);

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic rdy1, rdy2, rdy3;

    mse_pkg::s1_t     s1_reg, s1_next;
    mse_pkg::s2_t     s2_reg, s2_next;
    mse_pkg::mse_out_t out_reg, out_next;

    logic [31:0] imm_sext;

    assign rdy3 = !v3_reg || result.ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign instr.ready  = rdy1;
    assign result.valid = v3_reg;
    assign result.data  = out_reg;

    assign v1_next = rdy1 ? instr.valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;

    // decode
    always_comb
    begin
        imm_sext = {{16{instr.data.immediate[15]}}, instr.data.immediate};
        s1_next.a     = instr.data.first_operand;
        s1_next.b     = instr.data.second_operand;
        s1_next.shamt = instr.data.shift_amount;
        s1_next.pc4   = instr.data.instr_address + 32'd4;
        s1_next.boff  = {imm_sext[29:0], 2'b00};
        s1_next.sdata = 32'd0;
        s1_next.alu_op = mse_pkg::ALU_ZERO;
        s1_next.ctrl   = '0;
        unique case (instr.data.op)
            mse_pkg::OP_ADDIU:
            begin
                s1_next.alu_op = mse_pkg::ALU_ADD;
                s1_next.b = imm_sext;
                s1_next.ctrl.writes_register = 1'b1;
            end
            mse_pkg::OP_ANDI:
            begin
                s1_next.alu_op = mse_pkg::ALU_AND;
                s1_next.b = {16'd0, instr.data.immediate};
                s1_next.ctrl.writes_register = 1'b1;
            end
            mse_pkg::OP_ORI:
            begin
                s1_next.alu_op = mse_pkg::ALU_OR;
                s1_next.b = {16'd0, instr.data.immediate};
                s1_next.ctrl.writes_register = 1'b1;
            end
            mse_pkg::OP_LUI:
            begin
                s1_next.alu_op = mse_pkg::ALU_PASSB;
                s1_next.b = {instr.data.immediate, 16'd0};
                s1_next.ctrl.writes_register = 1'b1;
            end
            mse_pkg::OP_SLTIU:
            begin
                s1_next.alu_op = mse_pkg::ALU_SLTU;
                s1_next.b = imm_sext;
                s1_next.ctrl.writes_register = 1'b1;
            end
            mse_pkg::OP_LW:
            begin
                s1_next.alu_op = mse_pkg::ALU_ADD;
                s1_next.b = imm_sext;
                s1_next.ctrl.writes_register = 1'b1;
                s1_next.ctrl.reads_memory = 1'b1;
            end
            mse_pkg::OP_SW:
            begin
                s1_next.alu_op = mse_pkg::ALU_ADD;
                s1_next.b = imm_sext;
                s1_next.sdata = instr.data.second_operand;
                s1_next.ctrl.writes_memory = 1'b1;
            end
            mse_pkg::OP_BEQ:
            begin
                s1_next.ctrl.is_branch = 1'b1;
                s1_next.ctrl.is_beq = 1'b1;
            end
            mse_pkg::OP_BNE:
            begin
                s1_next.ctrl.is_branch = 1'b1;
            end
            mse_pkg::OP_J:
            begin
                s1_next.alu_op = mse_pkg::ALU_ZERO;
            end
            mse_pkg::OP_JAL:
            begin
                s1_next.ctrl.writes_register = 1'b1;
            end
            mse_pkg::OP_RTYPE:
            begin
                s1_next.ctrl.writes_register = 1'b1;
                unique case (instr.data.funct)
                    mse_pkg::FN_ADDU: s1_next.alu_op = mse_pkg::ALU_ADD;
                    mse_pkg::FN_SUBU: s1_next.alu_op = mse_pkg::ALU_SUB;
                    mse_pkg::FN_AND:  s1_next.alu_op = mse_pkg::ALU_AND;
                    mse_pkg::FN_OR:   s1_next.alu_op = mse_pkg::ALU_OR;
                    mse_pkg::FN_NOR:  s1_next.alu_op = mse_pkg::ALU_NOR;
                    mse_pkg::FN_SLTU: s1_next.alu_op = mse_pkg::ALU_SLTU;
                    mse_pkg::FN_SLL:  s1_next.alu_op = mse_pkg::ALU_SLL;
                    mse_pkg::FN_SRL:  s1_next.alu_op = mse_pkg::ALU_SRL;
                    mse_pkg::FN_JR:   s1_next.ctrl.writes_register = 1'b0;
                    default:
                    begin
                        s1_next.ctrl.writes_register = 1'b0;
                        s1_next.ctrl.illegal = 1'b1;
                    end
                endcase
            end
            default:
            begin
                s1_next.ctrl.illegal = 1'b1;
            end
        endcase
    end

    mse_alu u_alu (
        .s1 (s1_reg),
        .s2 (s2_next)
    );

    // select result
    always_comb
    begin
        unique case (s2_reg.alu_op)
            mse_pkg::ALU_ADD:   out_next.alu_result = s2_reg.sum;
            mse_pkg::ALU_SUB:   out_next.alu_result = s2_reg.diff[31:0];
            mse_pkg::ALU_AND:   out_next.alu_result = s2_reg.logic_r;
            mse_pkg::ALU_OR:    out_next.alu_result = s2_reg.logic_r;
            mse_pkg::ALU_NOR:   out_next.alu_result = s2_reg.logic_r;
            mse_pkg::ALU_SLTU:  out_next.alu_result = {31'd0, s2_reg.diff[32]};
            mse_pkg::ALU_SLL:   out_next.alu_result = s2_reg.shifted;
            mse_pkg::ALU_SRL:   out_next.alu_result = s2_reg.shifted;
            mse_pkg::ALU_PASSB: out_next.alu_result = s2_reg.b;
            default:            out_next.alu_result = 32'd0;
        endcase
        out_next.branch_taken = s2_reg.ctrl.is_branch
                                && (s2_reg.ctrl.is_beq ? s2_reg.eq : !s2_reg.eq);
        out_next.branch_target   = s2_reg.target;
        out_next.writes_register = s2_reg.ctrl.writes_register;
        out_next.reads_memory    = s2_reg.ctrl.reads_memory;
        out_next.writes_memory   = s2_reg.ctrl.writes_memory;
        out_next.store_data      = s2_reg.sdata;
        out_next.illegal         = s2_reg.ctrl.illegal;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // advance each stage only when it can hand its item on
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_reg <= s1_next;
        end
        if (rdy2)
        begin
            s2_reg <= s2_next;
        end
        if (rdy3)
        begin
            out_reg <= out_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.illegal) |->
            (result.data.alu_result == 32'd0 && !result.data.branch_taken
             && result.data.branch_target == 32'd0 && !result.data.writes_register
             && !result.data.reads_memory && !result.data.writes_memory
             && result.data.store_data == 32'd0))
        else $error("illegal item has side effects");

    a_branch_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.branch_taken) |->
            (!result.data.writes_register && result.data.alu_result == 32'd0
             && !result.data.writes_memory && !result.data.reads_memory))
        else $error("taken branch also writes");

    a_load_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.reads_memory) |->
            (result.data.writes_register && !result.data.writes_memory))
        else $error("load flags inconsistent");

    a_store_data: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.data.writes_memory) |->
            (result.data.store_data == 32'd0))
        else $error("store data leaks on non-store");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (instr.valid && instr.ready) |=> v1_reg)
        else $error("accepted item lost in first stage");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !result.ready && v2_reg) |=> (v3_reg && v2_reg))
        else $error("stalled pipeline dropped an item");
`endif

endmodule

### hdl/mse_alu.sv
`timescale 1ns / 1ps

module mse_alu (
    input  mse_pkg::s1_t s1,
    output mse_pkg::s2_t s2
);

    always_comb
    begin
        s2.alu_op = s1.alu_op;
        s2.ctrl   = s1.ctrl;
        s2.b      = s1.b;
        s2.sdata  = s1.sdata;
        s2.sum    = s1.a + s1.b;
        s2.diff   = {1'b0, s1.a} - {1'b0, s1.b};
        s2.eq     = (s1.a == s1.b);
        s2.target = s1.ctrl.is_branch ? (s1.pc4 + s1.boff) : 32'd0;
        unique case (s1.alu_op)
            mse_pkg::ALU_AND: s2.logic_r = s1.a & s1.b;
            mse_pkg::ALU_OR:  s2.logic_r = s1.a | s1.b;
            default:          s2.logic_r = ~(s1.a | s1.b);
        endcase
        if (s1.alu_op == mse_pkg::ALU_SLL)
        begin
            s2.shifted = s1.b << s1.shamt;
        end
        else
        begin
            s2.shifted = s1.b >> s1.shamt;
        end
    end

endmodule
